// File: rtl/arpr_pkg.sv
package arpr_pkg;

  // Header geometry: Ethernet header plus ARP header
  localparam int unsigned HDR_BYTES = 42;
  localparam logic [5:0] HDR_LEN  = 6'd42;
  localparam logic [5:0] LAST_IDX = 6'd41;

  // Header byte offsets that decide an ARP request
  localparam logic [5:0] OFS_ETYPE_HI = 6'd12;
  localparam logic [5:0] OFS_ETYPE_LO = 6'd13;
  localparam logic [5:0] OFS_OPER_HI  = 6'd20;
  localparam logic [5:0] OFS_OPER_LO  = 6'd21;

  localparam logic [7:0] ETYPE_ARP_HI = 8'h08;
  localparam logic [7:0] ETYPE_ARP_LO = 8'h06;
  localparam logic [7:0] OPER_HI      = 8'h00;
  localparam logic [7:0] OPER_REQ_LO  = 8'h01;
  localparam logic [7:0] OPER_REP_LO  = 8'h02;

  // Configuration register indexes
  localparam logic [1:0] CFG_OWN_MAC     = 2'd0;
  localparam logic [1:0] CFG_FORWARD_MAC = 2'd1;
  localparam logic [1:0] CFG_REWRITE_EN  = 2'd2;

  typedef enum logic [1:0] {
    VERD_FWD   = 2'd0,
    VERD_REPLY = 2'd1,
    VERD_DROP  = 2'd2
  } verdict_t;

  // Command passed from front to back
  typedef struct packed {
    logic       is_hdr;   // read out the buffered header
    logic [7:0] data;     // pass-through byte
    logic       last;
    verdict_t   verdict;
  } cmd_t;

endpackage

// File: rtl/arpr_ram.sv
module arpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 42
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/arpr_fifo.sv
module arpr_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  arpr_pkg::cmd_t push_cmd,
  input  logic           pop,
  output arpr_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  arpr_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CW'(DEPTH));
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push & ~do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop & ~do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/arpr_front.sv
module arpr_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     in_data,
  input  logic           in_last,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           ram_we,
  output logic [5:0]     ram_waddr,
  output logic [7:0]     ram_wdata,
  output logic           push,
  output arpr_pkg::cmd_t push_cmd,
  input  logic           fifo_full,
  input  logic           hdr_done,
  output logic           hdr_busy
);

  logic [5:0]         pos_r, pos_nxt;
  arpr_pkg::verdict_t kind_r, kind_nxt;
  logic               busy_r, busy_nxt;
  logic               m12_r, m13_r, m20_r, m21_r;
  logic               accept, hdr_phase, at_last_hdr, is_req;

  assign hdr_phase   = (pos_r != arpr_pkg::HDR_LEN);
  assign at_last_hdr = (pos_r == arpr_pkg::LAST_IDX);
  assign in_ready    = ~fifo_full & (~hdr_phase | ~busy_r);
  assign accept      = in_valid & in_ready;
  assign is_req      = m12_r & m13_r & m20_r & m21_r;
  assign hdr_busy    = busy_r;

  // Store header bytes
  assign ram_we    = accept & hdr_phase;
  assign ram_waddr = pos_r;
  assign ram_wdata = in_data;

  // Classify and queue commands
  always_comb begin
    push     = 1'b0;
    push_cmd = '{is_hdr: 1'b0, data: in_data, last: in_last, verdict: kind_r};
    pos_nxt  = pos_r;
    kind_nxt = kind_r;
    busy_nxt = busy_r & ~hdr_done;
    if (accept) begin
      if (!hdr_phase) begin
        push = 1'b1;
        if (in_last) begin
          pos_nxt  = '0;
          kind_nxt = arpr_pkg::VERD_FWD;
        end
      end else if (at_last_hdr) begin
        push             = 1'b1;
        push_cmd.is_hdr  = 1'b1;
        push_cmd.data    = '0;
        push_cmd.verdict = is_req ? arpr_pkg::VERD_REPLY : arpr_pkg::VERD_FWD;
        busy_nxt         = 1'b1;
        if (in_last) begin
          pos_nxt  = '0;
          kind_nxt = arpr_pkg::VERD_FWD;
        end else begin
          pos_nxt  = arpr_pkg::HDR_LEN;
          kind_nxt = is_req ? arpr_pkg::VERD_REPLY : arpr_pkg::VERD_FWD;
        end
      end else if (in_last) begin
        push             = 1'b1;
        push_cmd.data    = '0;
        push_cmd.last    = 1'b1;
        push_cmd.verdict = arpr_pkg::VERD_DROP;
        pos_nxt          = '0;
        kind_nxt         = arpr_pkg::VERD_FWD;
      end else begin
        pos_nxt = pos_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      kind_r <= arpr_pkg::VERD_FWD;
      busy_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      kind_r <= kind_nxt;
      busy_r <= busy_nxt;
    end
  end

  // Track the bytes that mark an ARP request
  always_ff @(posedge clk) begin
    if (accept) begin
      if (pos_r == arpr_pkg::OFS_ETYPE_HI) m12_r <= (in_data == arpr_pkg::ETYPE_ARP_HI);
      if (pos_r == arpr_pkg::OFS_ETYPE_LO) m13_r <= (in_data == arpr_pkg::ETYPE_ARP_LO);
      if (pos_r == arpr_pkg::OFS_OPER_HI)  m20_r <= (in_data == arpr_pkg::OPER_HI);
      if (pos_r == arpr_pkg::OFS_OPER_LO)  m21_r <= (in_data == arpr_pkg::OPER_REQ_LO);
    end
  end

endmodule

// File: rtl/arpr_back.sv
module arpr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  arpr_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  output logic           ram_re,
  output logic [5:0]     ram_raddr,
  input  logic [7:0]     ram_rdata,
  input  logic [47:0]    own_mac,
  input  logic [47:0]    forward_mac,
  input  logic           rewrite_en,
  output logic           hdr_done,
  output logic [7:0]     out_data,
  output logic           out_last,
  output logic [1:0]     out_verdict,
  output logic           out_valid,
  input  logic           out_ready
);

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_ISSUE = 3'b010,
    B_DATA  = 3'b100
  } bstate_t;

  bstate_t            st_r, st_nxt;
  logic [5:0]         j_r, j_nxt;
  logic               hlast_r, hlast_nxt;
  arpr_pkg::verdict_t hverd_r, hverd_nxt;
  logic               ov_r, ov_nxt;
  logic [7:0]         ob_r, ob_nxt;
  logic               ol_r, ol_nxt;
  arpr_pkg::verdict_t overd_r, overd_nxt;
  logic               out_free, reply;
  logic [7:0]         hdr_byte;

  // Byte k of a MAC in wire order, k = 0 is bits 47..40
  function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] k);
    logic [2:0] sel;
    sel = 3'd5 - k;
    return mac[{sel, 3'b000} +: 8];
  endfunction

  // Buffer address that feeds header output byte j
  function automatic logic [5:0] rd_addr_for(input logic [5:0] j, input logic rep,
                                             input logic rw);
    logic [5:0] a;
    a = j;
    if (rep) begin
      case (j) inside
        [6'd0:6'd5]:   a = j + 6'd6;
        [6'd28:6'd31]: a = j + 6'd10;
        [6'd32:6'd37]: a = j - 6'd10;
        [6'd38:6'd41]: a = j - 6'd10;
        default:       a = j;
      endcase
    end else if (rw) begin
      case (j) inside
        [6'd6:6'd11]: a = j - 6'd6;
        default:      a = j;
      endcase
    end
    return a;
  endfunction

  // Header output byte j from buffered data and configured MACs
  function automatic logic [7:0] hdr_out(input logic [5:0] j, input logic rep,
                                         input logic rw, input logic [7:0] rd,
                                         input logic [47:0] own, input logic [47:0] fwd);
    logic [7:0] b;
    logic [5:0] off6, off22;
    off6  = j - 6'd6;
    off22 = j - 6'd22;
    b     = rd;
    if (rep) begin
      case (j) inside
        [6'd6:6'd11]:  b = mac_byte(own, off6[2:0]);
        [6'd22:6'd27]: b = mac_byte(own, off22[2:0]);
        arpr_pkg::OFS_OPER_LO: b = arpr_pkg::OPER_REP_LO;
        default:       b = rd;
      endcase
    end else if (rw) begin
      case (j) inside
        [6'd0:6'd5]: b = mac_byte(fwd, j[2:0]);
        default:     b = rd;
      endcase
    end
    return b;
  endfunction

  assign out_free  = ~ov_r | out_ready;
  assign reply     = (hverd_r == arpr_pkg::VERD_REPLY);
  assign ram_raddr = rd_addr_for(j_r, reply, rewrite_en);
  assign hdr_byte  = hdr_out(j_r, reply, rewrite_en, ram_rdata, own_mac, forward_mac);

  // Sequence commands: pass bytes straight out, read headers one byte at a time via issue and data states
  always_comb begin
    st_nxt    = st_r;
    j_nxt     = j_r;
    hlast_nxt = hlast_r;
    hverd_nxt = hverd_r;
    ov_nxt    = ov_r & ~out_ready;
    ob_nxt    = ob_r;
    ol_nxt    = ol_r;
    overd_nxt = overd_r;
    cmd_pop   = 1'b0;
    ram_re    = 1'b0;
    hdr_done  = 1'b0;
    case (st_r)
      B_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          if (cmd.is_hdr) begin
            st_nxt    = B_ISSUE;
            j_nxt     = '0;
            hlast_nxt = cmd.last;
            hverd_nxt = cmd.verdict;
          end else begin
            ov_nxt    = 1'b1;
            ob_nxt    = cmd.data;
            ol_nxt    = cmd.last;
            overd_nxt = cmd.verdict;
          end
        end
      end
      B_ISSUE: begin
        if (out_free) begin
          ram_re   = 1'b1;
          st_nxt   = B_DATA;
          hdr_done = (j_r == arpr_pkg::LAST_IDX);
        end
      end
      B_DATA: begin
        ov_nxt    = 1'b1;
        ob_nxt    = hdr_byte;
        ol_nxt    = hlast_r & (j_r == arpr_pkg::LAST_IDX);
        overd_nxt = hverd_r;
        if (j_r == arpr_pkg::LAST_IDX) begin
          st_nxt = B_IDLE;
        end else begin
          j_nxt  = j_r + 6'd1;
          st_nxt = B_ISSUE;
        end
      end
      default: begin
        st_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    j_r     <= j_nxt;
    hlast_r <= hlast_nxt;
    hverd_r <= hverd_nxt;
    ob_r    <= ob_nxt;
    ol_r    <= ol_nxt;
    overd_r <= overd_nxt;
  end

  assign out_valid   = ov_r;
  assign out_data    = ob_r;
  assign out_last    = ol_r;
  assign out_verdict = overd_r;

endmodule

// File: rtl/arp_responder_frame_rewriter_core.sv
// Throughput: one input byte per cycle while the command queue has room and no header
// readout blocks; body bytes leave at one per cycle while out_tready is high. Header readout
// steps through an issue and a data state per byte, set by the registered read of the
// single header buffer; the next frame's header waits for it. A body byte or drop transaction
// is queued, then registered at output; a header byte also passes the issue and data states.
// Reset (rst_n, synchronous): clears control state and config registers; header buffer is not cleared.
module arp_responder_frame_rewriter_core #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] out_byte
  output logic        out_tlast,
  output logic [1:0]  out_tuser,   // [1:0] out_verdict
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata
);

  logic [47:0]    own_mac_r;
  logic [47:0]    forward_mac_r;
  logic           rewrite_en_r;

  logic           ram_we, ram_re;
  logic [5:0]     ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata, ram_rdata;
  logic           fifo_push, fifo_pop, fifo_empty, fifo_full;
  arpr_pkg::cmd_t push_cmd, head_cmd;
  logic           hdr_done, hdr_busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r     <= '0;
      forward_mac_r <= '0;
      rewrite_en_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        arpr_pkg::CFG_OWN_MAC:     own_mac_r     <= cfg_wdata;
        arpr_pkg::CFG_FORWARD_MAC: forward_mac_r <= cfg_wdata;
        arpr_pkg::CFG_REWRITE_EN:  rewrite_en_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  arpr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_tdata),
    .in_last   (in_tlast),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .push      (fifo_push),
    .push_cmd  (push_cmd),
    .fifo_full (fifo_full),
    .hdr_done  (hdr_done),
    .hdr_busy  (hdr_busy)
  );

  arpr_ram #(
    .WIDTH (8),
    .DEPTH (arpr_pkg::HDR_BYTES)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  arpr_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fifo_push),
    .push_cmd (push_cmd),
    .pop      (fifo_pop),
    .head     (head_cmd),
    .empty    (fifo_empty),
    .full     (fifo_full)
  );

  arpr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (head_cmd),
    .cmd_valid   (~fifo_empty),
    .cmd_pop     (fifo_pop),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .own_mac     (own_mac_r),
    .forward_mac (forward_mac_r),
    .rewrite_en  (rewrite_en_r),
    .hdr_done    (hdr_done),
    .out_data    (out_tdata),
    .out_last    (out_tlast),
    .out_verdict (out_tuser),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready)
  );

  // Header buffer is never written while the back end reads it
  a_buf_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("header buffer written during readout");

  // Header writes only happen while no readout is pending
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !hdr_busy)
    else $error("header write while previous header in flight");

  // Command queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_push |-> !fifo_full)
    else $error("command queue overflow");

  // A drop transaction always closes its frame
  a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == arpr_pkg::VERD_DROP) |-> out_tlast)
    else $error("drop transaction without last");

endmodule
